// ===== hw/rtl/rrqq_pkg.sv =====
// ----------------------------------------------------------------------------
// rrqq_pkg: shared types and constants of the round robin quantum queue
// Status codes, command codes, field widths and the controller interface.
// ----------------------------------------------------------------------------
package rrqq_pkg;

  // Default number of request entries.
  localparam int unsigned DepthDefault = 8;

  // Field widths.
  localparam int unsigned DemandW  = 8;
  localparam int unsigned QuantumW = 4;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned OccW     = 4;

  // Quantum after reset.
  localparam logic [QuantumW-1:0] QuantumReset = 4'd2;

  // Command codes.
  localparam logic CmdEnqueue = 1'b0;
  localparam logic CmdServe   = 1'b1;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_ENQUEUED   = 3'd0,
    ST_FULL_GRANT = 3'd1,
    ST_PART_GRANT = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_DROPPED    = 3'd4
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the request fields
    logic exec;  // update the queue and register the result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;  // no requests held
  } dp_stat_t;

endpackage

// ===== hw/rtl/rrqq_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrqq_ctrl: sequencing controller of the round robin quantum queue
// Accepts a request, inserts a store read state for serves of a non-empty queue, then executes.
// ----------------------------------------------------------------------------
module rrqq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  logic                  cmd_i,
  input  rrqq_pkg::dp_stat_t    stat_i,
  output logic                  busy,
  output rrqq_pkg::ctrl_cmd_t   cmd_o
);

  rrqq_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrqq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    busy       = 1'b1;
    unique case (state_q)
      rrqq_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          // Only a serve of a non-empty queue needs the head entry read.
          if ((cmd_i == rrqq_pkg::CmdServe) && !stat_i.empty) begin
            state_d = rrqq_pkg::S_READ;
          end else begin
            state_d = rrqq_pkg::S_EXEC;
          end
        end
      end
      rrqq_pkg::S_READ: begin
        state_d = rrqq_pkg::S_EXEC;
      end
      rrqq_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = rrqq_pkg::S_IDLE;
      end
      default: begin
        state_d = rrqq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rrqq_dpath.sv =====
// ----------------------------------------------------------------------------
// rrqq_dpath: datapath of the round robin quantum queue
// Request store, head and tail pointers, count, quantum and result registers.
// ----------------------------------------------------------------------------
module rrqq_dpath #(
  parameter int unsigned DEPTH = rrqq_pkg::DepthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rrqq_pkg::ctrl_cmd_t                cmd_i,
  output rrqq_pkg::dp_stat_t                 stat_o,
  input  logic                               req_cmd_i,
  input  logic [rrqq_pkg::DemandW-1:0]       req_demand_i,
  input  logic                               cfg_we_i,
  input  logic [rrqq_pkg::QuantumW-1:0]      cfg_quantum_i,
  output logic                               done_o,
  output logic [rrqq_pkg::StatusW-1:0]       status_o,
  output logic [rrqq_pkg::QuantumW-1:0]      granted_o,
  output logic [rrqq_pkg::DemandW-1:0]       leftover_o,
  output logic [rrqq_pkg::OccW-1:0]          occupancy_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [rrqq_pkg::DemandW-1:0]  mem_q [DEPTH];
  logic [rrqq_pkg::DemandW-1:0]  rd_data_q;
  logic                          wr_en;
  logic [rrqq_pkg::DemandW-1:0]  wr_data;

  logic [IdxW-1:0]               head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]               count_q, count_d;
  logic [rrqq_pkg::QuantumW-1:0] quantum_q;
  logic                          cmd_q;
  logic [rrqq_pkg::DemandW-1:0]  demand_q;

  logic                          done_q;
  rrqq_pkg::status_e             status_q, status_d;
  logic [rrqq_pkg::QuantumW-1:0] granted_q, granted_d;
  logic [rrqq_pkg::DemandW-1:0]  leftover_q, leftover_d;
  logic [rrqq_pkg::OccW-1:0]     occ_q;

  logic [rrqq_pkg::DemandW-1:0]  quantum_ext;
  logic [IdxW-1:0]               head_inc, tail_inc;

  assign quantum_ext  = {{(rrqq_pkg::DemandW - rrqq_pkg::QuantumW){1'b0}}, quantum_q};
  assign head_inc     = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign tail_inc     = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
  assign stat_o.empty = (count_q == '0);

  // Request store: one write port at the tail, registered read of the head.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[tail_q] <= wr_data;
    end
    rd_data_q <= mem_q[head_q];
  end

  // Queue update and result of one request.
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    wr_en      = 1'b0;
    wr_data    = demand_q;
    status_d   = rrqq_pkg::ST_EMPTY;
    granted_d  = '0;
    leftover_d = '0;
    if (cmd_q == rrqq_pkg::CmdEnqueue) begin
      if (count_q == FullCnt) begin
        status_d = rrqq_pkg::ST_DROPPED;
      end else begin
        wr_en    = cmd_i.exec;
        tail_d   = tail_inc;
        count_d  = count_q + 1'b1;
        status_d = rrqq_pkg::ST_ENQUEUED;
      end
    end else if (count_q != '0) begin
      head_d = head_inc;
      if (rd_data_q <= quantum_ext) begin
        granted_d = rd_data_q[rrqq_pkg::QuantumW-1:0];
        count_d   = count_q - 1'b1;
        status_d  = rrqq_pkg::ST_FULL_GRANT;
      end else begin
        // Grant one quantum and push the remainder back at the tail.
        granted_d  = quantum_q;
        leftover_d = rd_data_q - quantum_ext;
        wr_en      = cmd_i.exec;
        wr_data    = leftover_d;
        tail_d     = tail_inc;
        status_d   = rrqq_pkg::ST_PART_GRANT;
      end
    end
  end

  // Pointers, count, quantum and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      quantum_q <= rrqq_pkg::QuantumReset;
      done_q    <= 1'b0;
    end else begin
      done_q <= cmd_i.exec;
      if (cfg_we_i) begin
        quantum_q <= cfg_quantum_i;
      end
      if (cmd_i.exec) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
      end
    end
  end

  // Request capture and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q    <= req_cmd_i;
      demand_q <= req_demand_i;
    end
    if (cmd_i.exec) begin
      status_q   <= status_d;
      granted_q  <= granted_d;
      leftover_q <= leftover_d;
      occ_q      <= rrqq_pkg::OccW'(count_d);
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign granted_o   = granted_q;
  assign leftover_o  = leftover_q;
  assign occupancy_o = occ_q;

endmodule

// ===== hw/rtl/round_robin_quantum_queue.sv =====
// ----------------------------------------------------------------------------
// round_robin_quantum_queue: circular request queue served with a quantum
// Top level joining the sequencing controller and the queue datapath.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a clock edge with start high and busy low; cmd_i
//   selects enqueue (demand_i pushed at the tail) or serve (head popped,
//   at most one quantum granted, any remainder pushed back at the tail).
//   Each request yields exactly one result on status_o, granted_o,
//   leftover_o and occupancy_o, shown for one cycle while done_o is high.
//   The receiver cannot stall; it must take the result in that cycle.
//   An enqueue, or a serve of an empty queue, goes from the accepting edge
//   through the execute state to the result cycle; a serve of a held request
//   first passes the read state, the registered read of the request store.
//   busy drops in the result cycle, so a new request may start there; the
//   block takes no new request before the result of the last one.
//   The quantum is written with cfg_we_i and cfg_quantum_i while idle.
//   Reset empties the queue, sets the quantum to 2 and clears done_o; the
//   store contents are not cleared and are never used before written.
// ----------------------------------------------------------------------------
module round_robin_quantum_queue #(
  parameter int unsigned DEPTH = rrqq_pkg::DepthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               cmd_i,
  input  logic [rrqq_pkg::DemandW-1:0]       demand_i,
  input  logic                               cfg_we_i,
  input  logic [rrqq_pkg::QuantumW-1:0]      cfg_quantum_i,
  output logic                               done_o,
  output logic [rrqq_pkg::StatusW-1:0]       status_o,
  output logic [rrqq_pkg::QuantumW-1:0]      granted_o,
  output logic [rrqq_pkg::DemandW-1:0]       leftover_o,
  output logic [rrqq_pkg::OccW-1:0]          occupancy_o
);

  rrqq_pkg::ctrl_cmd_t ctrl_cmd;
  rrqq_pkg::dp_stat_t  dp_stat;

  // Sequencing controller.
  rrqq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .stat_i (dp_stat),
    .busy   (busy),
    .cmd_o  (ctrl_cmd)
  );

  // Queue datapath.
  rrqq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .stat_o        (dp_stat),
    .req_cmd_i     (cmd_i),
    .req_demand_i  (demand_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_quantum_i (cfg_quantum_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .granted_o     (granted_o),
    .leftover_o    (leftover_o),
    .occupancy_o   (occupancy_o)
  );

  // A result appears only once the block is free for the next request.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while block busy");

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a request");

  // Only a serve of a held request grants units or reports a remainder.
  a_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == rrqq_pkg::ST_ENQUEUED || status_o == rrqq_pkg::ST_EMPTY ||
     status_o == rrqq_pkg::ST_DROPPED)) |-> (granted_o == '0 && leftover_o == '0))
    else $error("grant or remainder on a non-serve result");

  // A partial grant always leaves a nonzero remainder.
  a_part_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == rrqq_pkg::ST_PART_GRANT) |-> (leftover_o != '0))
    else $error("partial grant without remainder");

endmodule

// ===== dv/rrqq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrqq_checker: result predictor and comparator for the quantum queue
// Watches the request, result and quantum ports, keeps its own copy of the
// queue and the quantum, and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module rrqq_checker #(
  parameter int unsigned DEPTH = rrqq_pkg::DepthDefault
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic                                    busy_i,
  input  logic                                    cmd_i,
  input  logic [rrqq_pkg::DemandW-1:0]            demand_i,
  input  logic                                    cfg_we_i,
  input  logic [rrqq_pkg::QuantumW-1:0]           cfg_quantum_i,
  input  logic                                    done_i,
  input  logic [rrqq_pkg::StatusW-1:0]            status_i,
  input  logic [rrqq_pkg::QuantumW-1:0]           granted_i,
  input  logic [rrqq_pkg::DemandW-1:0]            leftover_i,
  input  logic [rrqq_pkg::OccW-1:0]               occupancy_i,
  output int unsigned                             errors_o,
  output int unsigned                             pending_o,
  output int unsigned                             accepted_o,
  output int unsigned                             results_o,
  output int unsigned                             requeues_o,
  output int unsigned                             drops_o,
  output int unsigned                             empties_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);

  // One predicted result.
  typedef struct packed {
    rrqq_pkg::status_e                status;
    logic [rrqq_pkg::QuantumW-1:0]    granted;
    logic [rrqq_pkg::DemandW-1:0]     leftover;
    logic [rrqq_pkg::OccW-1:0]        occupancy;
  } grant_result_t;

  // Shadow copy of the queue and the quantum.
  logic [rrqq_pkg::DemandW-1:0]  demand_store [DEPTH];
  int unsigned                   head_idx;
  int unsigned                   tail_idx;
  int unsigned                   held;
  logic [rrqq_pkg::QuantumW-1:0] quantum;

  // Predictions waiting for their result, oldest first.
  grant_result_t pending_grants [$];

  int unsigned mismatches = 0;
  int unsigned accepted   = 0;
  int unsigned results    = 0;
  int unsigned requeues   = 0;
  int unsigned drops      = 0;
  int unsigned empties    = 0;

  function automatic int unsigned step_index(input int unsigned idx);
    return (idx + 1 == DEPTH) ? 0 : idx + 1;
  endfunction

  // Applies one request to the shadow queue and returns the result it causes.
  function automatic grant_result_t grant_request(input logic cmd,
                                                  input logic [rrqq_pkg::DemandW-1:0] dem);
    grant_result_t                r;
    logic [rrqq_pkg::DemandW-1:0] want;
    logic [rrqq_pkg::DemandW-1:0] q_ext;
    q_ext      = {{(rrqq_pkg::DemandW - rrqq_pkg::QuantumW){1'b0}}, quantum};
    r.status   = rrqq_pkg::ST_ENQUEUED;
    r.granted  = '0;
    r.leftover = '0;
    if (cmd == rrqq_pkg::CmdEnqueue) begin
      if (held == DEPTH) begin
        r.status = rrqq_pkg::ST_DROPPED;
        drops++;
      end else begin
        demand_store[IdxW'(tail_idx)] = dem;
        tail_idx = step_index(tail_idx);
        held++;
      end
    end else if (held == 0) begin
      r.status = rrqq_pkg::ST_EMPTY;
      empties++;
    end else begin
      want = demand_store[IdxW'(head_idx)];
      head_idx = step_index(head_idx);
      if (want <= q_ext) begin
        // The whole demand fits in one turn.
        r.status  = rrqq_pkg::ST_FULL_GRANT;
        r.granted = want[rrqq_pkg::QuantumW-1:0];
        held--;
      end else begin
        // One quantum is granted; the rest goes back to the tail.
        r.status   = rrqq_pkg::ST_PART_GRANT;
        r.granted  = quantum;
        r.leftover = want - q_ext;
        demand_store[IdxW'(tail_idx)] = r.leftover;
        tail_idx = step_index(tail_idx);
        requeues++;
      end
    end
    r.occupancy = held[rrqq_pkg::OccW-1:0];
    return r;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Results are checked before the request taken at the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    grant_result_t oldest;
    if (!rst_ni) begin
      head_idx = 0;
      tail_idx = 0;
      held     = 0;
      quantum  = rrqq_pkg::QuantumReset;
      pending_grants.delete();
    end else begin
      if (cfg_we_i) begin
        quantum = cfg_quantum_i;
      end
      if (done_i) begin
        if (pending_grants.size() == 0) begin
          $display("%0t: result with none expected, status %0d granted %0d",
                   $time, status_i, granted_i);
          $display("%0t: unexpected result also had leftover %0d occupancy %0d",
                   $time, leftover_i, occupancy_i);
          mismatches++;
        end else begin
          oldest = pending_grants.pop_front();
          results++;
          check_field("status", 8'(oldest.status), 8'(status_i));
          check_field("granted", 8'(oldest.granted), 8'(granted_i));
          check_field("leftover", oldest.leftover, leftover_i);
          check_field("occupancy", 8'(oldest.occupancy), 8'(occupancy_i));
        end
      end
      if (start_i && !busy_i) begin
        pending_grants.push_back(grant_request(cmd_i, demand_i));
        accepted++;
      end
    end
    errors_o   <= mismatches;
    pending_o  <= pending_grants.size();
    accepted_o <= accepted;
    results_o  <= results;
    requeues_o <= requeues;
    drops_o    <= drops;
    empties_o  <= empties;
  end

endmodule

// ===== dv/round_robin_quantum_queue_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_quantum_queue_test: stimulus and verdict for the quantum queue
// Drives directed and random enqueue and serve requests under several quantum
// settings with random gaps; a checker beside the block predicts the results.
// ----------------------------------------------------------------------------
module round_robin_quantum_queue_test;

  localparam int unsigned StallLimit = 1000;

  logic                          clk_i;
  logic                          rst_ni      = 1'b0;
  logic                          start       = 1'b0;
  logic                          busy;
  logic                          req_cmd     = rrqq_pkg::CmdEnqueue;
  logic [rrqq_pkg::DemandW-1:0]  req_demand  = '0;
  logic                          cfg_we      = 1'b0;
  logic [rrqq_pkg::QuantumW-1:0] cfg_quantum = '0;
  logic                          done;
  logic [rrqq_pkg::StatusW-1:0]  status;
  logic [rrqq_pkg::QuantumW-1:0] granted;
  logic [rrqq_pkg::DemandW-1:0]  leftover;
  logic [rrqq_pkg::OccW-1:0]     occupancy;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned accepted;
  int unsigned results;
  int unsigned requeues;
  int unsigned drops;
  int unsigned empties;
  int unsigned stall_cycles = 0;
  bit          steady = 1'b0;

  round_robin_quantum_queue u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (req_cmd),
    .demand_i     (req_demand),
    .cfg_we_i     (cfg_we),
    .cfg_quantum_i(cfg_quantum),
    .done_o       (done),
    .status_o     (status),
    .granted_o    (granted),
    .leftover_o   (leftover),
    .occupancy_o  (occupancy)
  );

  rrqq_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (req_cmd),
    .demand_i     (req_demand),
    .cfg_we_i     (cfg_we),
    .cfg_quantum_i(cfg_quantum),
    .done_i       (done),
    .status_i     (status),
    .granted_i    (granted),
    .leftover_i   (leftover),
    .occupancy_i  (occupancy),
    .errors_o     (fail_count),
    .pending_o    (pending),
    .accepted_o   (accepted),
    .results_o    (results),
    .requeues_o   (requeues),
    .drops_o      (drops),
    .empties_o    (empties)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Ends the run when neither a request nor a result moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("%0t: watchdog expired after %0d quiet cycles", $time, StallLimit);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Sender gap before a request, empty in steady stretches.
  function automatic int unsigned idle_gap();
    int unsigned n;
    n = 0;
    if (!steady) begin
      while ($urandom_range(99) < 34) n++;
    end
    return n;
  endfunction

  // Presents one request and returns at the edge that accepts it.
  task automatic send_request(input logic cmd, input logic [rrqq_pkg::DemandW-1:0] dem);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    req_cmd    <= cmd;
    req_demand <= dem;
    do @(posedge clk_i); while (busy);
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic drain_queue();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_quantum(input logic [rrqq_pkg::QuantumW-1:0] q);
    drain_queue();
    cfg_we      <= 1'b1;
    cfg_quantum <= q;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Random requests; most demands are near the quantum so grants finish.
  task automatic run_phase(input int unsigned n, input int unsigned enq_pct,
                           input logic [rrqq_pkg::QuantumW-1:0] q);
    logic                         cmd;
    logic [rrqq_pkg::DemandW-1:0] dem;
    repeat (n) begin
      cmd = ($urandom_range(99) < enq_pct) ? rrqq_pkg::CmdEnqueue : rrqq_pkg::CmdServe;
      case ($urandom_range(7))
        0:       dem = 8'h00;
        1:       dem = 8'hFF;
        2:       dem = 8'($urandom_range(255));
        default: dem = 8'($urandom_range(3 * q + 1));
      endcase
      send_request(cmd, dem);
    end
  endtask

  initial begin
    logic [rrqq_pkg::QuantumW-1:0] q;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Serve of an empty queue, then a zero quantum on zero and nonzero demands.
    send_request(rrqq_pkg::CmdServe, 8'h00);
    set_quantum(4'd0);
    send_request(rrqq_pkg::CmdEnqueue, 8'h00);
    send_request(rrqq_pkg::CmdEnqueue, 8'h05);
    send_request(rrqq_pkg::CmdServe, 8'hFF);
    send_request(rrqq_pkg::CmdServe, 8'h00);

    // Back to the reset quantum: fill to the top, drop, requeue while full.
    set_quantum(4'd2);
    send_request(rrqq_pkg::CmdServe, 8'h00);
    send_request(rrqq_pkg::CmdEnqueue, 8'h00);
    send_request(rrqq_pkg::CmdEnqueue, 8'hFF);
    send_request(rrqq_pkg::CmdEnqueue, 8'h01);
    send_request(rrqq_pkg::CmdEnqueue, 8'h02);
    send_request(rrqq_pkg::CmdEnqueue, 8'h55);
    send_request(rrqq_pkg::CmdEnqueue, 8'hAA);
    send_request(rrqq_pkg::CmdEnqueue, 8'h80);
    send_request(rrqq_pkg::CmdEnqueue, 8'h07);
    send_request(rrqq_pkg::CmdServe, 8'h00);
    send_request(rrqq_pkg::CmdServe, 8'h00);
    send_request(rrqq_pkg::CmdServe, 8'h00);
    send_request(rrqq_pkg::CmdServe, 8'h00);
    send_request(rrqq_pkg::CmdServe, 8'h00);

    // Largest quantum on a large demand.
    set_quantum(4'd15);
    send_request(rrqq_pkg::CmdServe, 8'h00);

    // Random phases, each under its own quantum; one phase runs without gaps.
    for (int p = 0; p < 10; p++) begin
      case (p % 3)
        0:       q = 4'd1;
        1:       q = 4'd15;
        default: q = 4'($urandom_range(2, 14));
      endcase
      set_quantum(q);
      steady = (p == 4);
      run_phase(55, 40 + 10 * (p % 3), q);
    end
    steady = 1'b0;

    drain_queue();
    repeat (6) @(posedge clk_i);
    $display("Covered %0d requests and %0d results over quanta 0, 1, 2, 15 and random ones.",
             accepted, results);
    $display("Saw %0d partial grants requeued, %0d drops when full, %0d serves when empty.",
             requeues, drops, empties);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rrqq_pkg.sv
hw/rtl/rrqq_ctrl.sv
hw/rtl/rrqq_dpath.sv
hw/rtl/round_robin_quantum_queue.sv
dv/rrqq_checker.sv
dv/round_robin_quantum_queue_test.sv
